### hdl/assert_macros.svh
// Assertion macros shared by the photon statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PPSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/ppsu_pkg.sv
// Types and constants of the photon pixel statistics update block.
package ppsu_pkg;

  localparam int CntW  = 32;
  localparam int PhW   = 24;
  localparam int RadW  = 32;
  localparam int TauW  = 40;
  localparam int SumW  = TauW + 1;
  localparam int BW    = 35;
  localparam int QuoW  = 32;
  localparam int RemW  = BW;
  localparam int RootW = 32;
  localparam int SqRemW = RootW + 1;
  localparam int Chans = 3;

  localparam int StepsPerStage = 2;
  localparam int DivStages  = QuoW / StepsPerStage;
  localparam int SqrtStages = RootW / StepsPerStage;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam logic [QCntW-1:0] QFullCnt = QCntW'(QDepth);

  // floor(y/3) = (y * Third26) >> 26 for y < 2^25
  localparam logic [24:0] Third26  = 25'd22369622;
  localparam logic [7:0]  CntWhole = 8'd170;

  typedef struct packed {
    logic [CntW-1:0] old_count;
    logic [PhW-1:0]  new_photons;
    logic [RadW-1:0] old_radius;
    logic [TauW-1:0] tau_red;
    logic [TauW-1:0] tau_green;
    logic [TauW-1:0] tau_blue;
    logic [TauW-1:0] phi_red;
    logic [TauW-1:0] phi_green;
    logic [TauW-1:0] phi_blue;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0] updated_count;
    logic [RadW-1:0] updated_radius;
    logic [TauW-1:0] updated_tau_red;
    logic [TauW-1:0] updated_tau_green;
    logic [TauW-1:0] updated_tau_blue;
  } out_item_t;

  typedef struct packed {
    logic                       bypass;
    logic [CntW-1:0]            count;
    logic [RadW-1:0]            radius;
    logic [Chans-1:0][SumW-1:0] sum;
  } carry_t;

  typedef struct packed {
    carry_t          carry;
    logic [BW-1:0]   divisor;
    logic [QuoW-1:0] rem0;
  } prep_t;

  typedef struct packed {
    logic             full;
    logic [QCntW-1:0] count;
  } q_stat_t;

endpackage

### hdl/ppsu_pix_if.sv
// Input channel carrying one pixel's statistics.
interface ppsu_pix_if;
  logic                valid;
  logic                ready;
  ppsu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/ppsu_res_if.sv
// Output channel carrying one pixel's updated statistics.
interface ppsu_res_if;
  logic                valid;
  logic                ready;
  ppsu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/ppsu_front.sv
// Front stage: accepts a pixel, forms divisor, new count and flux sums.
module ppsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ppsu_pix_if.sink        pix_i,
  output logic            prep_valid_o,
  output ppsu_pkg::prep_t prep_o,
  input  logic            prep_ready_i
);

  logic            vld_q;
  ppsu_pkg::prep_t prep_q, prep_d;
  logic [32:0]     scaled_sum;
  logic [24:0]     twice_m;
  logic [49:0]     frac_prod;
  logic [31:0]     whole;
  logic [33:0]     cnt_sum;
  logic            take;

  assign pix_i.ready  = !vld_q || prep_ready_i;
  assign take         = pix_i.valid && pix_i.ready;
  assign prep_valid_o = vld_q;
  assign prep_o       = prep_q;

  always_comb begin
    scaled_sum = {1'b0, pix_i.data.old_count} + {1'b0, pix_i.data.new_photons, 8'b0};
    prep_d.divisor = {2'b0, scaled_sum} + {1'b0, scaled_sum, 1'b0};
    prep_d.rem0    = {pix_i.data.new_photons, 8'b0};
    prep_d.carry.bypass = (pix_i.data.new_photons == '0);
    prep_d.carry.radius = pix_i.data.old_radius;
    // 512m/3 = 170m + floor(2m/3)
    twice_m   = {pix_i.data.new_photons, 1'b0};
    frac_prod = twice_m * ppsu_pkg::Third26;
    whole     = pix_i.data.new_photons * ppsu_pkg::CntWhole;
    cnt_sum   = {2'b0, pix_i.data.old_count} + {2'b0, whole} + {10'b0, frac_prod[49:26]};
    prep_d.carry.count = (cnt_sum[33:32] != 2'b0) ? '1 : cnt_sum[31:0];
    if (prep_d.carry.bypass) begin
      prep_d.carry.sum[0] = {1'b0, pix_i.data.tau_red};
      prep_d.carry.sum[1] = {1'b0, pix_i.data.tau_green};
      prep_d.carry.sum[2] = {1'b0, pix_i.data.tau_blue};
    end else begin
      prep_d.carry.sum[0] = {1'b0, pix_i.data.tau_red} + {1'b0, pix_i.data.phi_red};
      prep_d.carry.sum[1] = {1'b0, pix_i.data.tau_green} + {1'b0, pix_i.data.phi_green};
      prep_d.carry.sum[2] = {1'b0, pix_i.data.tau_blue} + {1'b0, pix_i.data.phi_blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prep_q <= prep_d;
    end
  end

endmodule

### hdl/ppsu_queue.sv
// Short queue between the front stage and the arithmetic pipeline.
module ppsu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  ppsu_pkg::prep_t   push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output ppsu_pkg::prep_t   pop_data_o,
  input  logic              pop_i,
  output ppsu_pkg::q_stat_t stat_o
);

  ppsu_pkg::prep_t                mem_q [ppsu_pkg::QDepth];
  logic [ppsu_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [ppsu_pkg::QCntW-1:0]     cnt_q;
  logic                           push;

  assign push_ready_o = (cnt_q != ppsu_pkg::QFullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign stat_o.full  = !push_ready_o;
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == ppsu_pkg::QPtrW'(ppsu_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == ppsu_pkg::QPtrW'(ppsu_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hdl/ppsu_back.sv
// Back pipeline: ratio division, square root, scaling and output register.
module ppsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  ppsu_pkg::prep_t q_data_i,
  output logic            q_pop_o,
  ppsu_res_if.source      res_o
);

  localparam int DS = ppsu_pkg::DivStages;
  localparam int SS = ppsu_pkg::SqrtStages;

  logic en;

  // divider stages
  logic [DS-1:0]                dv_v_q;
  ppsu_pkg::carry_t             dv_c_q [DS];
  logic [ppsu_pkg::BW-1:0]      dv_b_q [DS];
  logic [ppsu_pkg::RemW-1:0]    dv_r_q [DS];
  logic [ppsu_pkg::QuoW-1:0]    dv_q_q [DS];

  // square root stages
  logic [SS-1:0]                sq_v_q;
  ppsu_pkg::carry_t             sq_c_q [SS];
  logic [ppsu_pkg::QuoW:0]      sq_rq_q [SS];
  logic [ppsu_pkg::RootW-1:0]   sq_x_q [SS];
  logic [ppsu_pkg::RootW-1:0]   sq_root_q [SS];
  logic [ppsu_pkg::SqRemW-1:0]  sq_rem_q [SS];

  logic [ppsu_pkg::QuoW:0]      ratio;

  // multiply stage
  logic                                 mul_v_q;
  ppsu_pkg::carry_t                     mul_c_q;
  logic [63:0]                          mul_rad_q;
  logic [ppsu_pkg::Chans-1:0][63:0]     mul_lo_q;
  logic [ppsu_pkg::Chans-1:0][40:0]     mul_hi_q;
  logic                                 mul_full_q;

  logic                                 out_v_q;
  ppsu_pkg::out_item_t                  out_q, out_d;
  logic [ppsu_pkg::Chans-1:0][ppsu_pkg::TauW-1:0] tau_res;

  // the whole pipeline holds while a result waits at the output
  assign en      = !out_v_q || res_o.ready;
  assign q_pop_o = en && q_valid_i;

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic                       in_v;
    ppsu_pkg::carry_t           in_c;
    logic [ppsu_pkg::BW-1:0]    b_in;
    logic [ppsu_pkg::RemW-1:0]  r_in, r_nx;
    logic [ppsu_pkg::QuoW-1:0]  q_in, q_nx;

    if (i == 0) begin : g_head
      assign in_v = q_valid_i;
      assign in_c = q_data_i.carry;
      assign b_in = q_data_i.divisor;
      assign r_in = {3'b0, q_data_i.rem0};
      assign q_in = '0;
    end else begin : g_link
      assign in_v = dv_v_q[i-1];
      assign in_c = dv_c_q[i-1];
      assign b_in = dv_b_q[i-1];
      assign r_in = dv_r_q[i-1];
      assign q_in = dv_q_q[i-1];
    end

    always_comb begin
      logic [ppsu_pkg::RemW:0] r2;
      r_nx = r_in;
      q_nx = q_in;
      for (int j = 0; j < ppsu_pkg::StepsPerStage; j++) begin
        r2 = {r_nx, 1'b0};
        if (r2 >= {1'b0, b_in}) begin
          r_nx = ppsu_pkg::RemW'(r2 - {1'b0, b_in});
          q_nx = {q_nx[ppsu_pkg::QuoW-2:0], 1'b1};
        end else begin
          r_nx = r2[ppsu_pkg::RemW-1:0];
          q_nx = {q_nx[ppsu_pkg::QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (en) begin
        dv_v_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_c_q[i] <= in_c;
        dv_b_q[i] <= b_in;
        dv_r_q[i] <= r_nx;
        dv_q_q[i] <= q_nx;
      end
    end
  end

  // ratio in Q1.32, may be exactly one
  assign ratio = {1'b1, {ppsu_pkg::QuoW{1'b0}}} - {1'b0, dv_q_q[DS-1]};

  for (genvar i = 0; i < SS; i++) begin : g_sqrt
    logic                         in_v;
    ppsu_pkg::carry_t             in_c;
    logic [ppsu_pkg::QuoW:0]      rq_in;
    logic [ppsu_pkg::RootW-1:0]   x_in, x_nx, root_in, root_nx;
    logic [ppsu_pkg::SqRemW-1:0]  rem_in, rem_nx;

    if (i == 0) begin : g_head
      assign in_v    = dv_v_q[DS-1];
      assign in_c    = dv_c_q[DS-1];
      assign rq_in   = ratio;
      assign x_in    = ratio[ppsu_pkg::RootW-1:0];
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_link
      assign in_v    = sq_v_q[i-1];
      assign in_c    = sq_c_q[i-1];
      assign rq_in   = sq_rq_q[i-1];
      assign x_in    = sq_x_q[i-1];
      assign root_in = sq_root_q[i-1];
      assign rem_in  = sq_rem_q[i-1];
    end

    always_comb begin
      logic [ppsu_pkg::SqRemW+1:0] r4;
      logic [ppsu_pkg::SqRemW+1:0] trial;
      x_nx    = x_in;
      root_nx = root_in;
      rem_nx  = rem_in;
      for (int j = 0; j < ppsu_pkg::StepsPerStage; j++) begin
        r4    = {rem_nx, x_nx[ppsu_pkg::RootW-1 -: 2]};
        trial = {1'b0, root_nx, 2'b01};
        if (r4 >= trial) begin
          rem_nx  = ppsu_pkg::SqRemW'(r4 - trial);
          root_nx = {root_nx[ppsu_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_nx  = r4[ppsu_pkg::SqRemW-1:0];
          root_nx = {root_nx[ppsu_pkg::RootW-2:0], 1'b0};
        end
        x_nx = {x_nx[ppsu_pkg::RootW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i] <= 1'b0;
      end else if (en) begin
        sq_v_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_c_q[i]    <= in_c;
        sq_rq_q[i]   <= rq_in;
        sq_x_q[i]    <= x_nx;
        sq_root_q[i] <= root_nx;
        sq_rem_q[i]  <= rem_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= sq_v_q[SS-1];
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_c_q    <= sq_c_q[SS-1];
      mul_full_q <= sq_rq_q[SS-1][ppsu_pkg::QuoW];
      mul_rad_q  <= sq_c_q[SS-1].radius * sq_root_q[SS-1];
      for (int c = 0; c < ppsu_pkg::Chans; c++) begin
        mul_lo_q[c] <= sq_c_q[SS-1].sum[c][31:0] * sq_rq_q[SS-1][ppsu_pkg::QuoW-1:0];
        mul_hi_q[c] <= sq_c_q[SS-1].sum[c][40:32] * sq_rq_q[SS-1][ppsu_pkg::QuoW-1:0];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    logic [ppsu_pkg::SumW:0] t;
    for (int c = 0; c < ppsu_pkg::Chans; c++) begin
      if (mul_full_q) begin
        t = {1'b0, mul_c_q.sum[c]};
      end else begin
        t = {1'b0, mul_hi_q[c]} + {10'b0, mul_lo_q[c][63:32]};
      end
      if (mul_c_q.bypass) begin
        tau_res[c] = mul_c_q.sum[c][ppsu_pkg::TauW-1:0];
      end else if (t[ppsu_pkg::SumW:ppsu_pkg::TauW] != 2'b0) begin
        tau_res[c] = '1;
      end else begin
        tau_res[c] = t[ppsu_pkg::TauW-1:0];
      end
    end
    out_d.updated_count     = mul_c_q.count;
    out_d.updated_radius    = mul_c_q.bypass ? mul_c_q.radius : mul_rad_q[63:32];
    out_d.updated_tau_red   = tau_res[0];
    out_d.updated_tau_green = tau_res[1];
    out_d.updated_tau_blue  = tau_res[2];
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

endmodule

### hdl/photon_pixel_statistics_update.sv
// Photon pixel statistics update: takes one pixel per cycle while the output is taken and
// returns its new photon count, search radius and flux. The count ratio is found by a
// restoring divider and its square root by a digit-by-digit root unit, each pipelined two
// bits per stage over 16 stages; one pixel per cycle is sustained while results are taken.
// A four-beat queue behind the input register keeps taking beats, until it fills, while a
// result waits at the output register.
`include "assert_macros.svh"

module photon_pixel_statistics_update (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppsu_pix_if.sink   pix_i,
  ppsu_res_if.source res_o
);

  logic              prep_valid, prep_ready;
  ppsu_pkg::prep_t   prep;
  logic              q_valid, q_pop;
  ppsu_pkg::prep_t   q_data;
  ppsu_pkg::q_stat_t q_stat;

  ppsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .prep_valid_o (prep_valid),
    .prep_o       (prep),
    .prep_ready_i (prep_ready)
  );

  ppsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (prep_valid),
    .push_data_i  (prep),
    .push_ready_o (prep_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_i        (q_pop),
    .stat_o       (q_stat)
  );

  ppsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

  `PPSU_ASSERT_ALWAYS(a_q_bound, q_stat.count <= ppsu_pkg::QFullCnt, "queue over depth")
  `PPSU_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
  `PPSU_ASSERT(a_full_valid, q_stat.full |-> q_valid, "full queue shows no beat")
  `PPSU_ASSERT(a_front_hold, prep_valid && !prep_ready |=> prep_valid, "front beat dropped")

endmodule
